// ===== rtl/q6k_pkg.sv =====
// ----------------------------------------------------------------------------
// q6k_pkg: shared constants and types
// Byte offsets of the super-block layout, controller commands, an fp helper.
// ----------------------------------------------------------------------------
package q6k_pkg;
  localparam int unsigned MAX_ROW_BLOCKS_DEF = 1024;
  localparam logic [7:0] QH_FIRST  = 8'd128;
  localparam logic [7:0] SC_FIRST  = 8'd192;
  localparam logic [7:0] D_LOW_AT  = 8'd208;
  localparam logic [7:0] D_HIGH_AT = 8'd209;
  localparam logic [31:0] QNAN     = 32'h7FC00000;

  typedef struct packed {
    logic       store_lo;
    logic       emit_w;
    logic       store_sc;
    logic       store_dl;
    logic       start_pairs;
    logic [7:0] at;
    logic [3:0] pair_k;
    logic       pair_valid;
  } q6k_cmd_t;

  // fp16 to fp32, subnormals normalised (priority search over 10 bits)
  function automatic logic [31:0] half_to_float(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [7:0]  e;
    logic [31:0] bits;
    int          lz;
    ex  = h[14:10];
    man = h[9:0];
    lz  = 0;
    bits = {h[15], 31'd0};
    if (ex == 5'd31) begin
      bits = {h[15], 8'hFF, man, 13'd0};
    end else if (ex == 5'd0) begin
      if (man != 10'd0) begin
        for (int i = 0; i < 10; i++) begin
          if (man[9 - i] && lz == 0) lz = i + 1;
        end
        e   = 8'(113 - lz);
        man = 10'(man << lz);
        bits = {h[15], e, man, 13'd0};
      end
    end else begin
      bits = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
    return bits;
  endfunction
endpackage

// ===== rtl/q6k_ctrl.sv =====
// ----------------------------------------------------------------------------
// q6k_ctrl: byte sequencer
// Counts bytes of a super-block and runs the 16-pair emission after d.
// ----------------------------------------------------------------------------
module q6k_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  input  logic             out_busy,
  output q6k_pkg::q6k_cmd_t cmd
);
  import q6k_pkg::*;

  localparam logic ST_BYTES = 1'b0;
  localparam logic ST_PAIRS = 1'b1;

  logic       state_r, state_nxt;
  logic [7:0] at_r, at_nxt;
  logic [3:0] k_r, k_nxt;
  logic       take;
  logic       adv;

  assign adv      = !out_busy || out_ready;
  assign in_ready = (state_r == ST_BYTES) && adv;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    at_nxt    = at_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.at    = at_r;
    cmd.pair_k = k_r;
    unique case (state_r)
      ST_BYTES: begin
        if (take) begin
          cmd.store_lo    = at_r < QH_FIRST;
          cmd.emit_w      = at_r >= QH_FIRST && at_r < SC_FIRST;
          cmd.store_sc    = at_r >= SC_FIRST && at_r < D_LOW_AT;
          cmd.store_dl    = at_r == D_LOW_AT;
          cmd.start_pairs = at_r >= D_HIGH_AT;
          at_nxt = (at_r >= D_HIGH_AT) ? 8'd0 : at_r + 8'd1;
          if (at_r >= D_HIGH_AT) begin
            state_nxt = ST_PAIRS;
            k_nxt     = 4'd0;
          end
        end
      end
      ST_PAIRS: begin
        if (adv) begin
          cmd.pair_valid = 1'b1;
          k_nxt = k_r + 4'd1;
          if (k_r == 4'd15) state_nxt = ST_BYTES;
        end
      end
      default: state_nxt = ST_BYTES;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BYTES;
      at_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      at_r    <= at_nxt;
      k_r     <= k_nxt;
    end
  end
endmodule

// ===== rtl/q6k_dp.sv =====
// ----------------------------------------------------------------------------
// q6k_dp: storage, weight assembly and scale products
// Holds nibble and scale stores, multiplies d by each scale, drives output.
// ----------------------------------------------------------------------------
module q6k_dp #(
  parameter int unsigned MAX_ROW_BLOCKS = q6k_pkg::MAX_ROW_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q6k_pkg::q6k_cmd_t cmd,
  input  logic [7:0]        in_byte,
  input  logic [10:0]       cfg_blocks,
  input  logic              out_ready,
  output logic              out_busy,
  output logic              out_valid,
  output logic              out_kind,
  output logic [9:0]        out_block_number,
  output logic [7:0]        out_position,
  output logic [5:0]        out_weight_a,
  output logic [5:0]        out_weight_b,
  output logic [5:0]        out_weight_c,
  output logic [5:0]        out_weight_d,
  output logic [31:0]       out_scale_bits,
  output logic [31:0]       out_offset_bits,
  output logic              out_last_of_block,
  output logic              out_last_of_row
);
  import q6k_pkg::*;

  localparam int BW = (MAX_ROW_BLOCKS > 1) ? $clog2(MAX_ROW_BLOCKS) : 1;

  logic [7:0]  lo_mem [128];
  logic [7:0]  sc_mem [16];
  logic [7:0]  dl_r;
  logic [31:0] d_r;
  logic [BW-1:0] blk_r;
  logic [7:0]  lo0_r, lo1_r;
  logic [7:0]  qh_r;
  logic [6:0]  rd0, rd1;
  logic [16:0] nblk;
  logic        row_end;
  logic        valid_r;

  // clamp block count
  always_comb begin
    nblk = {6'd0, cfg_blocks};
    if (nblk == 17'd0) nblk = 17'd1;
    if (nblk > 17'(MAX_ROW_BLOCKS)) nblk = 17'(MAX_ROW_BLOCKS);
  end
  assign row_end = (17'(blk_r) + 17'd1) >= nblk;

  assign rd0 = {cmd.at[5], 6'd0} | {2'd0, cmd.at[4:0]};
  assign rd1 = rd0 | 7'd32;

  always_ff @(posedge clk) begin
    if (cmd.store_lo) lo_mem[cmd.at[6:0]] <= in_byte;
    if (cmd.store_sc) sc_mem[cmd.at[3:0]] <= in_byte;
    if (cmd.store_dl) dl_r <= in_byte;
    if (cmd.start_pairs) d_r <= half_to_float({in_byte, dl_r});
    if (cmd.emit_w) begin
      lo0_r <= lo_mem[rd0];
      lo1_r <= lo_mem[rd1];
      qh_r  <= in_byte;
    end
  end

  // fp32 product of d by a signed 8-bit integer; exact, so no rounding
  logic [7:0]  s8;
  logic [7:0]  mag;
  logic [18:0] prod;
  logic [31:0] ws, wo;
  logic [8:0]  ebias;
  logic        sgn;
  int          msb;
  always_comb begin
    s8   = sc_mem[cmd.pair_k];
    mag  = s8[7] ? 8'(-s8) : s8;
    sgn  = d_r[31] ^ s8[7];
    prod = {1'b1, d_r[22:13]} * mag;
    msb  = 0;
    for (int i = 0; i < 19; i++) if (prod[i]) msb = i;
    ws = '0;
    wo = '0;
    ebias = '0;
    if (d_r[30:23] == 8'hFF) begin
      if (d_r[22:0] != 0 || mag == 0) ws = QNAN;
      else ws = {sgn, 8'hFF, 23'd0};
      wo = ws;
    end else if (d_r[30:0] == 0 || mag == 0) begin
      ws = {sgn, 31'd0};
      wo = ws;
    end else begin
      ebias = 9'({1'b0, d_r[30:23]} + 9'(msb) - 9'd10);
      ws = {sgn, ebias[7:0], 23'((prod << (23 - msb)) & 23'h7FFFFF)};
      wo = {sgn, 8'(ebias + 9'd5), ws[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      blk_r   <= '0;
    end else begin
      if (cmd.emit_w) valid_r <= 1'b1;
      else if (cmd.pair_valid) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (cmd.pair_valid && cmd.pair_k == 4'd15)
        blk_r <= row_end ? '0 : blk_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_w || cmd.pair_valid) begin
      out_kind          <= cmd.pair_valid;
      out_block_number  <= 10'(blk_r);
      out_position      <= cmd.pair_valid ? {4'd0, cmd.pair_k}
                                          : {cmd.at[5], 2'd0, cmd.at[4:0]};
      out_scale_bits    <= cmd.pair_valid ? ws : 32'd0;
      out_offset_bits   <= cmd.pair_valid ? wo : 32'd0;
      out_last_of_block <= cmd.pair_valid && cmd.pair_k == 4'd15;
      out_last_of_row   <= cmd.pair_valid && cmd.pair_k == 4'd15 && row_end;
    end
  end

  logic       wsel_r;
  always_ff @(posedge clk) begin
    if (cmd.emit_w || cmd.pair_valid) wsel_r <= cmd.emit_w;
  end

  assign out_valid    = valid_r;
  assign out_busy     = valid_r;
  assign out_weight_a = wsel_r ? {qh_r[1:0], lo0_r[3:0]} : 6'd0;
  assign out_weight_b = wsel_r ? {qh_r[3:2], lo1_r[3:0]} : 6'd0;
  assign out_weight_c = wsel_r ? {qh_r[5:4], lo0_r[7:4]} : 6'd0;
  assign out_weight_d = wsel_r ? {qh_r[7:6], lo1_r[7:4]} : 6'd0;
endmodule

// ===== rtl/q6k_superblock_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// q6k_superblock_unpacker_unit: Q6_K super-block unpacker
// Feed super-block bytes on in_; words leave on out_.
//
// Use: bytes arrive on in_byte with in_valid/in_ready. A high-bit byte
// yields one word of four 6-bit weights, valid the cycle after the byte
// is taken. Other bytes yield nothing. The last d byte yields sixteen
// scale/offset words, one per cycle while the receiver is ready; the
// first is valid once the sequencer is in its pair state and the output
// register has loaded it. in_ready is low while they are emitted, so
// the sequencer holds the input while the pairs leave. A stalled
// receiver holds the output word, and in_ready drops while that word
// waits. cfg_we writes blocks_per_row; the user must do so only while
// idle, the block does not enforce it. Reset (rst_n low, synchronous)
// clears byte and block counters and the output valid; stores need no
// clearing since each entry is written before it is read.
// ----------------------------------------------------------------------------
module q6k_superblock_unpacker_unit #(
  parameter int unsigned MAX_ROW_BLOCKS = q6k_pkg::MAX_ROW_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [9:0]  out_block_number,
  output logic [7:0]  out_position,
  output logic [5:0]  out_weight_a,
  output logic [5:0]  out_weight_b,
  output logic [5:0]  out_weight_c,
  output logic [5:0]  out_weight_d,
  output logic [31:0] out_scale_bits,
  output logic [31:0] out_offset_bits,
  output logic        out_last_of_block,
  output logic        out_last_of_row
);
  import q6k_pkg::*;

  logic [10:0] cfg_r;
  q6k_cmd_t    cmd;
  logic        busy;
  logic        ovalid;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= 11'd1;
    else if (cfg_we) cfg_r <= cfg_wdata;
  end

  q6k_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready,
    .out_ready(out_ready), .out_busy(busy), .cmd
  );

  q6k_dp #(.MAX_ROW_BLOCKS(MAX_ROW_BLOCKS)) u_dp (
    .clk, .rst_n, .cmd, .in_byte, .cfg_blocks(cfg_r),
    .out_ready, .out_busy(busy), .out_valid(ovalid),
    .out_kind, .out_block_number, .out_position,
    .out_weight_a, .out_weight_b, .out_weight_c, .out_weight_d,
    .out_scale_bits, .out_offset_bits, .out_last_of_block, .out_last_of_row
  );

  assign out_valid = ovalid;
endmodule

// ===== tb/tb_q6k_superblock_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_q6k_superblock_unpacker_unit: self-checking bench for the Q6_K unpacker
// Streams one super-block and part of the next with random content and an
// fp16 d drawn from normal, infinite, NaN, subnormal, signed zero and
// largest values, with random idling on both channels. A scoreboard
// predicts every weight word and scale/offset word and checks them in order.
// ----------------------------------------------------------------------------
module tb_q6k_superblock_unpacker_unit;
  import q6k_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [9:0]  blk;
    logic [7:0]  pos;
    logic [5:0]  wa;
    logic [5:0]  wb;
    logic [5:0]  wc;
    logic [5:0]  wd;
    logic [31:0] scale;
    logic [31:0] offset;
    logic        last_blk;
    logic        last_row;
  } q6k_word_t;

  class q6k_scoreboard;
    logic [7:0]  lo_nib[128];
    logic [7:0]  scales[16];
    logic [7:0]  d_lo;
    int unsigned byte_at;
    int unsigned blk_at;
    int unsigned row_len;
    q6k_word_t   expected[$];
    int          errors;

    function new();
      byte_at = 0;
      blk_at  = 0;
      row_len = 1;
      errors  = 0;
    endfunction

    function logic [31:0] pack_fp(bit s, int unsigned p, int e);
      logic [31:0] pv;
      int          msb;
      pv  = p;
      msb = 0;
      if (p == 0) return {s, 31'd0};
      for (int i = 0; i < 32; i++) if (pv[i]) msb = i;
      pv = pv << (23 - msb);
      return {s, 8'(msb + e + 127), pv[22:0]};
    endfunction

    function void note_byte(logic [7:0] b);
      q6k_word_t   w;
      logic [15:0] half;
      logic [7:0]  lo0, lo1;
      int unsigned j, h, l, lim, mant, mag;
      int          ex, sv;
      bit          s, row_end;
      w = '0;
      if (byte_at < QH_FIRST) begin
        lo_nib[byte_at] = b;
      end else if (byte_at < SC_FIRST) begin
        j = byte_at - QH_FIRST;
        h = j / 32;
        l = j % 32;
        lo0 = lo_nib[h * 64 + l];
        lo1 = lo_nib[h * 64 + l + 32];
        w.blk = 10'(blk_at);
        w.pos = 8'(h * 128 + l);
        w.wa = {b[1:0], lo0[3:0]};
        w.wb = {b[3:2], lo1[3:0]};
        w.wc = {b[5:4], lo0[7:4]};
        w.wd = {b[7:6], lo1[7:4]};
        expected.push_back(w);
      end else if (byte_at < D_LOW_AT) begin
        scales[byte_at - SC_FIRST] = b;
      end else if (byte_at == D_LOW_AT) begin
        d_lo = b;
      end else begin
        half = {b, d_lo};
        ex = half[14:10];
        lim = (row_len < 1) ? 1 : (row_len > MAX_ROW_BLOCKS_DEF) ? MAX_ROW_BLOCKS_DEF : row_len;
        row_end = (blk_at + 1) >= lim;
        for (int k = 0; k < 16; k++) begin
          sv  = $signed(scales[k]);
          mag = (sv < 0) ? -sv : sv;
          s   = half[15] ^ (sv < 0);
          w = '0;
          w.kind = 1'b1;
          w.blk = 10'(blk_at);
          w.pos = 8'(k);
          if (ex == 31) begin
            w.scale = (half[9:0] != 0 || mag == 0) ? QNAN : {s, 8'hFF, 23'd0};
            w.offset = w.scale;
          end else begin
            mant = (ex == 0) ? half[9:0] : 1024 + half[9:0];
            ex = (ex == 0) ? -24 : ex - 25;
            w.scale = pack_fp(s, mant * mag, ex);
            w.offset = pack_fp(s, mant * mag, ex + 5);
            ex = half[14:10];
          end
          w.last_blk = (k == 15);
          w.last_row = (k == 15) && row_end;
          expected.push_back(w);
        end
        blk_at = row_end ? 0 : blk_at + 1;
      end
      byte_at = (byte_at >= D_HIGH_AT) ? 0 : byte_at + 1;
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check(q6k_word_t a);
      q6k_word_t e;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, a);
        return;
      end
      e = expected.pop_front();
      cmp("kind", e.kind, a.kind);
      cmp("block_number", e.blk, a.blk);
      cmp("position", e.pos, a.pos);
      cmp("weight_a", e.wa, a.wa);
      cmp("weight_b", e.wb, a.wb);
      cmp("weight_c", e.wc, a.wc);
      cmp("weight_d", e.wd, a.wd);
      cmp("scale_bits", e.scale, a.scale);
      cmp("offset_bits", e.offset, a.offset);
      cmp("last_of_block", e.last_blk, a.last_blk);
      cmp("last_of_row", e.last_row, a.last_row);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  q6k_word_t   out_word;
  q6k_scoreboard sb = new();
  bit          hold_req;
  bit          sender_quiet;
  int          idle_cycles;

  always #2 clk = ~clk;

  q6k_superblock_unpacker_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_word.kind), .out_block_number(out_word.blk),
    .out_position(out_word.pos), .out_weight_a(out_word.wa),
    .out_weight_b(out_word.wb), .out_weight_c(out_word.wc),
    .out_weight_d(out_word.wd), .out_scale_bits(out_word.scale),
    .out_offset_bits(out_word.offset), .out_last_of_block(out_word.last_blk),
    .out_last_of_row(out_word.last_row)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_word);
    if (rst_n && in_valid && in_ready) sb.note_byte(in_byte);
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int stall, count;
    out_ready <= 1'b0;
    count = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = ((count / 50) % 3 == 0) ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      count++;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_row_len(logic [10:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.row_len = n;
  endtask

  task automatic send_block(logic [15:0] d, bit extremes, int nbytes);
    logic [7:0] b;
    sender_quiet = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom_range(0, 255));
      if (extremes && i < 8) b = i[0] ? 8'hFF : 8'h00;
      if (i >= SC_FIRST && i < SC_FIRST + 5) begin
        case (i - SC_FIRST)
          0: b = 8'h80;
          1: b = 8'h7F;
          2: b = 8'h00;
          3: b = 8'h01;
          default: b = 8'hFF;
        endcase
      end
      if (i == D_LOW_AT) b = d[7:0];
      if (i == D_HIGH_AT) b = d[15:8];
      send_byte(b);
    end
  endtask

  initial begin
    logic [15:0] d;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_byte <= '0;
    hold_req = 1'b1;
    sender_quiet = 1'b0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    case ($urandom_range(0, 5))
      0: d = 16'h3C00 ^ 16'($urandom_range(0, 16'h0FFF));
      1: d = 16'h7C00;
      2: d = 16'h7E01;
      3: d = 16'h03FF;
      4: d = 16'h8000;
      default: d = 16'hFBFF;
    endcase
    set_row_len(11'd2047);
    send_block(d, 1'b1, 210);
    drain();
    send_block(16'd0, 1'b0, 150);
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== q6k_superblock_unpacker_unit.f =====
rtl/q6k_pkg.sv
rtl/q6k_ctrl.sv
rtl/q6k_dp.sv
rtl/q6k_superblock_unpacker_unit.sv
tb/tb_q6k_superblock_unpacker_unit.sv
